>>> design/uhts_pkg.sv
// Shared widths, codes and payload types of the USB host transfer sequencer.
`timescale 1ns / 1ps

package uhts_pkg;

  // Field widths
  localparam int REQ_W    = 2;
  localparam int LEN_W    = 16;
  localparam int CNT_W    = 10;
  localparam int ACT_W    = 3;
  localparam int STS_W    = 2;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Setup packet length
  localparam logic [CNT_W-1:0] SETUP_BYTES = 10'd8;

  // Register reset values
  localparam logic [CNT_W-1:0]  MPS_RESET   = 10'd64;
  localparam logic [TICK_W-1:0] TLIM_RESET  = 16'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd1;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EVENT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  // Actions
  localparam logic [ACT_W-1:0] ACT_SETUP      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REQ_IN     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_OUT_DATA   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNLOAD     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STATUS_OUT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_STATUS_IN  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd6;
  localparam logic [ACT_W-1:0] ACT_DONE       = 3'd7;

  // Done status codes
  localparam logic [STS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STS_W-1:0] ST_STALL  = 2'd1;
  localparam logic [STS_W-1:0] ST_NORESP = 2'd2;

  // One request item as held in the input register
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             is_control;
    logic             dir_in;
    logic [LEN_W-1:0] total_length;
    logic             tx_pending;
    logic             rx_ready;
    logic             got_stall;
    logic             got_error;
    logic             got_nak_timeout;
    logic [CNT_W-1:0] rx_count;
  } req_item_t;

  // One result entry, without the last mark
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [CNT_W-1:0] byte_count;
    logic [STS_W-1:0] done_status;
  } res_item_t;

endpackage

>>> design/uhts_req_if.sv
// Request channel: start, endpoint status event and timer tick transactions.
`timescale 1ns / 1ps

interface uhts_req_if;
  logic                        valid;
  logic                        ready;
  logic [uhts_pkg::REQ_W-1:0]  req_type;
  logic                        is_control;
  logic                        dir_in;
  logic [uhts_pkg::LEN_W-1:0]  total_length;
  logic                        tx_pending;
  logic                        rx_ready;
  logic                        got_stall;
  logic                        got_error;
  logic                        got_nak_timeout;
  logic [uhts_pkg::CNT_W-1:0]  rx_count;

  modport source (
    output valid, req_type, is_control, dir_in, total_length, tx_pending,
           rx_ready, got_stall, got_error, got_nak_timeout, rx_count,
    input  ready
  );

  modport sink (
    input  valid, req_type, is_control, dir_in, total_length, tx_pending,
           rx_ready, got_stall, got_error, got_nak_timeout, rx_count,
    output ready
  );
endinterface

>>> design/uhts_res_if.sv
// Result channel: one command or completion per transaction.
`timescale 1ns / 1ps

interface uhts_res_if;
  logic                        valid;
  logic                        ready;
  logic [uhts_pkg::ACT_W-1:0]  action;
  logic [uhts_pkg::CNT_W-1:0]  byte_count;
  logic [uhts_pkg::STS_W-1:0]  done_status;
  logic                        last;

  modport source (
    output valid, action, byte_count, done_status, last,
    input  ready
  );

  modport sink (
    input  valid, action, byte_count, done_status, last,
    output ready
  );
endinterface

>>> design/uhts_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface uhts_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [uhts_pkg::CFG_IDX_W-1:0]  index;
  logic [uhts_pkg::CFG_DAT_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> design/usb_host_transfer_sequencer.sv
// Top level of the USB host transfer sequencer.
`timescale 1ns / 1ps

// Runs one USB host transfer at a time (control: setup, data, status; bulk: data only) and
// issues endpoint commands on the result channel. Each request transaction is taken into an
// input register, decoded against the transfer state, and its zero to three results are
// loaded into a three-entry result register that drains one result per cycle while the sink
// is ready, with last set on the final result of that request. A request that causes several
// results holds the result register until they drain; with single-result requests and a
// ready sink the block takes one request per cycle. The first result is offered from the
// result register once the request has left the input register; a busy result register
// holds the request there. A request that causes no result still passes the input register.
// The result register, not the state logic, sets the sustained rate. Configuration writes
// are always accepted and must be made while no transfer is running.
module usb_host_transfer_sequencer (
  input  logic             clk,
  input  logic             rst,
  uhts_req_if.sink         req,
  uhts_res_if.source       res,
  uhts_cfg_if.sink         cfg
);

  // Transfer phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_SETUP      = 3'd1;
  localparam logic [2:0] PH_DATA_IN    = 3'd2;
  localparam logic [2:0] PH_DATA_OUT   = 3'd3;
  localparam logic [2:0] PH_STATUS_OUT = 3'd4;
  localparam logic [2:0] PH_STATUS_IN  = 3'd5;

  typedef struct packed {
    uhts_pkg::res_item_t r;
    logic [2:0]          ph;
  } next_cmd_t;

  // Next data packet, or status stage, or done once no bytes are left
  function automatic next_cmd_t next_data(input logic [uhts_pkg::LEN_W-1:0] bl,
                                          input logic ctrl, input logic dir,
                                          input logic [uhts_pkg::CNT_W-1:0] ps);
    next_cmd_t nc;
    logic [uhts_pkg::LEN_W-1:0] ps_w;
    nc   = '0;
    ps_w = {{(uhts_pkg::LEN_W-uhts_pkg::CNT_W){1'b0}}, ps};
    if (bl != '0) begin
      if (dir) begin
        nc.r.action = uhts_pkg::ACT_REQ_IN;
        nc.ph       = PH_DATA_IN;
      end else begin
        nc.r.action     = uhts_pkg::ACT_OUT_DATA;
        nc.r.byte_count = (bl < ps_w) ? bl[uhts_pkg::CNT_W-1:0] : ps;
        nc.ph           = PH_DATA_OUT;
      end
    end else if (ctrl) begin
      nc.r.action = dir ? uhts_pkg::ACT_STATUS_OUT : uhts_pkg::ACT_STATUS_IN;
      nc.ph       = dir ? PH_STATUS_OUT : PH_STATUS_IN;
    end else begin
      nc.r.action      = uhts_pkg::ACT_DONE;
      nc.r.done_status = uhts_pkg::ST_OK;
      nc.ph            = PH_IDLE;
    end
    return nc;
  endfunction

  function automatic uhts_pkg::res_item_t mk_res(input logic [uhts_pkg::ACT_W-1:0] act,
                                                 input logic [uhts_pkg::CNT_W-1:0] cnt,
                                                 input logic [uhts_pkg::STS_W-1:0] sts);
    uhts_pkg::res_item_t r;
    r.action      = act;
    r.byte_count  = cnt;
    r.done_status = sts;
    return r;
  endfunction

  // Configuration registers
  logic [uhts_pkg::CNT_W-1:0]  max_packet_size;
  logic [uhts_pkg::TICK_W-1:0] timeout_limit;

  // Transfer state
  logic [2:0]                  phase, phase_next;
  logic [uhts_pkg::LEN_W-1:0]  bytes_left, bytes_left_next;
  logic                        control_mode, control_mode_next;
  logic                        direction_in, direction_in_next;
  logic [uhts_pkg::TICK_W-1:0] wait_ticks, wait_ticks_next;

  // Input register
  logic                  in_valid;
  uhts_pkg::req_item_t   in_item;

  // Result register
  logic [1:0]            res_left, res_cnt_next;
  uhts_pkg::res_item_t   res_ent [3];
  uhts_pkg::res_item_t   res_new [3];

  logic process;
  logic res_take;
  logic in_take;

  // Decode helpers
  logic                        waiting_for_rx;
  logic                        complete;
  logic [uhts_pkg::CNT_W-1:0]  pkt_size;
  logic [uhts_pkg::LEN_W-1:0]  pkt_size_w;
  logic [uhts_pkg::LEN_W-1:0]  rx_count_w;
  logic [uhts_pkg::LEN_W-1:0]  out_chunk;
  logic [uhts_pkg::LEN_W-1:0]  bl_after_in;
  logic [uhts_pkg::LEN_W-1:0]  bl_after_out;
  logic [uhts_pkg::TICK_W:0]   ticks_inc;
  logic                        tick_expired;
  next_cmd_t                   nc;

  // Handshakes
  assign res_take  = res.valid && res.ready;
  assign process   = in_valid && ((res_left == 2'd0) || ((res_left == 2'd1) && res.ready));
  assign req.ready = !in_valid || process;
  assign in_take   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // Drive result port from the head entry
  assign res.valid       = (res_left != 2'd0);
  assign res.action      = res_ent[0].action;
  assign res.byte_count  = res_ent[0].byte_count;
  assign res.done_status = res_ent[0].done_status;
  assign res.last        = (res_left == 2'd1);

  // Packet arithmetic
  assign waiting_for_rx = (phase == PH_DATA_IN) || (phase == PH_STATUS_IN);
  assign complete       = waiting_for_rx ? in_item.rx_ready : !in_item.tx_pending;
  assign pkt_size       = (max_packet_size == '0) ? 10'd1 : max_packet_size;
  assign pkt_size_w     = {{(uhts_pkg::LEN_W-uhts_pkg::CNT_W){1'b0}}, pkt_size};
  assign rx_count_w     = {{(uhts_pkg::LEN_W-uhts_pkg::CNT_W){1'b0}}, in_item.rx_count};
  assign out_chunk      = (bytes_left < pkt_size_w) ? bytes_left : pkt_size_w;
  assign bl_after_out   = bytes_left - out_chunk;
  assign bl_after_in    = ((rx_count_w >= bytes_left) || (in_item.rx_count < pkt_size))
                          ? '0 : (bytes_left - rx_count_w);
  assign ticks_inc      = {1'b0, wait_ticks} + 17'd1;
  assign tick_expired   = ticks_inc[uhts_pkg::TICK_W] ||
                          (ticks_inc[uhts_pkg::TICK_W-1:0] >= timeout_limit);

  // Decode one request against the transfer state
  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    control_mode_next = control_mode;
    direction_in_next = direction_in;
    wait_ticks_next   = wait_ticks;
    res_cnt_next      = 2'd0;
    res_new[0]        = '0;
    res_new[1]        = '0;
    res_new[2]        = '0;
    nc                = '0;
    unique case (in_item.req_type)
      uhts_pkg::REQ_START: begin
        if (phase == PH_IDLE) begin
          control_mode_next = in_item.is_control;
          direction_in_next = in_item.dir_in;
          bytes_left_next   = in_item.total_length;
          wait_ticks_next   = '0;
          res_cnt_next      = 2'd1;
          if (in_item.is_control) begin
            res_new[0] = mk_res(uhts_pkg::ACT_SETUP, uhts_pkg::SETUP_BYTES, uhts_pkg::ST_OK);
            phase_next = PH_SETUP;
          end else begin
            nc         = next_data(in_item.total_length, 1'b0, in_item.dir_in, pkt_size);
            res_new[0] = nc.r;
            phase_next = nc.ph;
          end
        end
      end
      uhts_pkg::REQ_EVENT: begin
        if ((phase != PH_IDLE) && complete) begin
          wait_ticks_next = '0;
          if (in_item.got_stall || in_item.got_error || in_item.got_nak_timeout) begin
            res_new[0]   = mk_res(uhts_pkg::ACT_CLEAR, '0, uhts_pkg::ST_OK);
            res_new[1]   = mk_res(uhts_pkg::ACT_DONE, '0,
                                  in_item.got_stall ? uhts_pkg::ST_STALL : uhts_pkg::ST_NORESP);
            res_cnt_next = 2'd2;
            phase_next   = PH_IDLE;
          end else begin
            unique case (phase)
              PH_SETUP: begin
                nc           = next_data(bytes_left, control_mode, direction_in, pkt_size);
                res_new[0]   = nc.r;
                res_cnt_next = 2'd1;
                phase_next   = nc.ph;
              end
              PH_DATA_IN: begin
                nc              = next_data(bl_after_in, control_mode, direction_in, pkt_size);
                res_new[0]      = mk_res(uhts_pkg::ACT_UNLOAD, in_item.rx_count, uhts_pkg::ST_OK);
                res_new[1]      = mk_res(uhts_pkg::ACT_CLEAR, '0, uhts_pkg::ST_OK);
                res_new[2]      = nc.r;
                res_cnt_next    = 2'd3;
                bytes_left_next = bl_after_in;
                phase_next      = nc.ph;
              end
              PH_DATA_OUT: begin
                nc              = next_data(bl_after_out, control_mode, direction_in, pkt_size);
                res_new[0]      = nc.r;
                res_cnt_next    = 2'd1;
                bytes_left_next = bl_after_out;
                phase_next      = nc.ph;
              end
              PH_STATUS_OUT: begin
                res_new[0]   = mk_res(uhts_pkg::ACT_DONE, '0, uhts_pkg::ST_OK);
                res_cnt_next = 2'd1;
                phase_next   = PH_IDLE;
              end
              PH_STATUS_IN: begin
                res_new[0]   = mk_res(uhts_pkg::ACT_CLEAR, '0, uhts_pkg::ST_OK);
                res_new[1]   = mk_res(uhts_pkg::ACT_DONE, '0, uhts_pkg::ST_OK);
                res_cnt_next = 2'd2;
                phase_next   = PH_IDLE;
              end
              default: begin
                phase_next = phase;
              end
            endcase
          end
        end
      end
      uhts_pkg::REQ_TICK: begin
        if (phase != PH_IDLE) begin
          if (tick_expired) begin
            res_new[0]      = mk_res(uhts_pkg::ACT_DONE, '0, uhts_pkg::ST_NORESP);
            res_cnt_next    = 2'd1;
            phase_next      = PH_IDLE;
            wait_ticks_next = '0;
          end else begin
            wait_ticks_next = ticks_inc[uhts_pkg::TICK_W-1:0];
          end
        end
      end
      default: begin
        res_cnt_next = 2'd0;
      end
    endcase
  end

  // Control state, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      res_left        <= 2'd0;
      phase           <= PH_IDLE;
      bytes_left      <= '0;
      control_mode    <= 1'b0;
      direction_in    <= 1'b0;
      wait_ticks      <= '0;
      max_packet_size <= uhts_pkg::MPS_RESET;
      timeout_limit   <= uhts_pkg::TLIM_RESET;
    end else begin
      // Hold or advance the input register
      if (in_take) begin
        in_valid <= 1'b1;
      end else if (process) begin
        in_valid <= 1'b0;
      end
      // Load a new result group or drop the delivered head
      if (process) begin
        res_left     <= res_cnt_next;
        phase        <= phase_next;
        bytes_left   <= bytes_left_next;
        control_mode <= control_mode_next;
        direction_in <= direction_in_next;
        wait_ticks   <= wait_ticks_next;
      end else if (res_take) begin
        res_left <= res_left - 2'd1;
      end
      // Register writes
      if (cfg.valid) begin
        case (cfg.index)
          uhts_pkg::REG_MAX_PACKET: max_packet_size <= cfg.data[uhts_pkg::CNT_W-1:0];
          uhts_pkg::REG_TIMEOUT:    timeout_limit   <= cfg.data;
          default:                  timeout_limit   <= timeout_limit;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.req_type        <= req.req_type;
      in_item.is_control      <= req.is_control;
      in_item.dir_in          <= req.dir_in;
      in_item.total_length    <= req.total_length;
      in_item.tx_pending      <= req.tx_pending;
      in_item.rx_ready        <= req.rx_ready;
      in_item.got_stall       <= req.got_stall;
      in_item.got_error       <= req.got_error;
      in_item.got_nak_timeout <= req.got_nak_timeout;
      in_item.rx_count        <= req.rx_count;
    end
    if (process) begin
      res_ent[0] <= res_new[0];
      res_ent[1] <= res_new[1];
      res_ent[2] <= res_new[2];
    end else if (res_take) begin
      res_ent[0] <= res_ent[1];
      res_ent[1] <= res_ent[2];
    end
  end

  // Done always closes the result group of its transaction
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.action == uhts_pkg::ACT_DONE)) |-> res.last)
    else $error("done result not marked last");

  // Tick count stays cleared while no transfer runs
  a_idle_ticks: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (wait_ticks == '0))
    else $error("tick count nonzero while idle");

  // Data phase agrees with the transfer direction
  a_dir_phase: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_DATA_IN) |-> direction_in) and ((phase == PH_DATA_OUT) |-> !direction_in))
    else $error("data phase disagrees with direction");

  // Setup and status stages exist only in control transfers
  a_status_ctl: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_STATUS_OUT) || (phase == PH_STATUS_IN) || (phase == PH_SETUP))
      |-> control_mode)
    else $error("control stage in bulk transfer");

  // Byte counts travel only with setup, OUT data and unload
  a_count_act: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.byte_count != '0)) |->
      ((res.action == uhts_pkg::ACT_SETUP) || (res.action == uhts_pkg::ACT_OUT_DATA) ||
       (res.action == uhts_pkg::ACT_UNLOAD)))
    else $error("byte count on wrong action");

endmodule

>>> dv/usb_host_transfer_sequencer_tb.sv
// Self-checking testbench for the USB host transfer sequencer: shadow state tracker and drivers.
`timescale 1ns / 1ps

typedef enum logic [3:0] {
  XF_IDLE,
  XF_SETUP,
  XF_DATA_IN,
  XF_DATA_OUT,
  XF_STATUS_OUT,
  XF_STATUS_IN
} xfer_phase_t;

typedef struct packed {
  uhts_pkg::res_item_t body;
  logic                last;
} cmd_t;

// Track the transfer state and queue the commands each request should produce
class transfer_shadow;
  logic [uhts_pkg::CNT_W-1:0]  mps;
  logic [uhts_pkg::TICK_W-1:0] tlim;
  xfer_phase_t                 phase;
  logic [uhts_pkg::LEN_W-1:0]  remaining;
  bit                          ctl;
  bit                          dir_in;
  bit                          await_rx;
  logic [uhts_pkg::TICK_W-1:0] ticks;
  cmd_t                        pending_cmds[$];
  cmd_t                        burst[$];
  int                          mismatches;

  function new();
    mps = uhts_pkg::MPS_RESET;
    tlim = uhts_pkg::TLIM_RESET;
    phase = XF_IDLE;
    remaining = '0;
    ctl = 1'b0;
    dir_in = 1'b0;
    await_rx = 1'b0;
    ticks = '0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [uhts_pkg::CFG_IDX_W-1:0] idx,
                        logic [uhts_pkg::CFG_DAT_W-1:0] data);
    if (idx == uhts_pkg::REG_MAX_PACKET)
      mps = data[uhts_pkg::CNT_W-1:0];
    else if (idx == uhts_pkg::REG_TIMEOUT)
      tlim = data;
  endfunction

  // A packet size of zero behaves as one byte
  function int unsigned pkt_len();
    return (mps == '0) ? 1 : int'(mps);
  endfunction

  function logic [uhts_pkg::CNT_W-1:0] chunk();
    return (remaining < pkt_len()) ? remaining[uhts_pkg::CNT_W-1:0]
                                   : uhts_pkg::CNT_W'(pkt_len());
  endfunction

  function void push(logic [uhts_pkg::ACT_W-1:0] act, logic [uhts_pkg::CNT_W-1:0] cnt,
                     logic [uhts_pkg::STS_W-1:0] sts);
    cmd_t c;
    c.body.action = act;
    c.body.byte_count = cnt;
    c.body.done_status = sts;
    c.last = 1'b0;
    burst.push_back(c);
  endfunction

  function void begin_wait(xfer_phase_t ph);
    phase = ph;
    await_rx = (ph == XF_DATA_IN || ph == XF_STATUS_IN);
    ticks = '0;
  endfunction

  function void conclude(logic [uhts_pkg::STS_W-1:0] sts);
    push(uhts_pkg::ACT_DONE, '0, sts);
    phase = XF_IDLE;
    await_rx = 1'b0;
    ticks = '0;
  endfunction

  // Issue the next data packet, or move on to the status stage or done
  function void issue_next();
    if (remaining != '0) begin
      if (dir_in) begin
        push(uhts_pkg::ACT_REQ_IN, '0, uhts_pkg::ST_OK);
        begin_wait(XF_DATA_IN);
      end else begin
        push(uhts_pkg::ACT_OUT_DATA, chunk(), uhts_pkg::ST_OK);
        begin_wait(XF_DATA_OUT);
      end
    end else if (ctl) begin
      if (dir_in) begin
        push(uhts_pkg::ACT_STATUS_OUT, '0, uhts_pkg::ST_OK);
        begin_wait(XF_STATUS_OUT);
      end else begin
        push(uhts_pkg::ACT_STATUS_IN, '0, uhts_pkg::ST_OK);
        begin_wait(XF_STATUS_IN);
      end
    end else begin
      conclude(uhts_pkg::ST_OK);
    end
  endfunction

  // Apply one accepted request transaction; return 0 for a wrong phase or an unused type
  function bit note_request(uhts_pkg::req_item_t it);
    cmd_t c;
    bit   taken;
    burst.delete();
    taken = 1'b1;
    case (it.req_type)
      uhts_pkg::REQ_START: begin
        if (phase != XF_IDLE) begin
          taken = 1'b0;
        end else begin
          ctl = it.is_control;
          dir_in = it.dir_in;
          remaining = it.total_length;
          if (ctl) begin
            push(uhts_pkg::ACT_SETUP, uhts_pkg::SETUP_BYTES, uhts_pkg::ST_OK);
            begin_wait(XF_SETUP);
          end else begin
            issue_next();
          end
        end
      end
      uhts_pkg::REQ_EVENT: begin
        if (phase == XF_IDLE) begin
          taken = 1'b0;
        end else if (await_rx ? it.rx_ready : !it.tx_pending) begin
          // Stall outranks error and NAK timeout, which end alike
          if (it.got_stall) begin
            push(uhts_pkg::ACT_CLEAR, '0, uhts_pkg::ST_OK);
            conclude(uhts_pkg::ST_STALL);
          end else if (it.got_error || it.got_nak_timeout) begin
            push(uhts_pkg::ACT_CLEAR, '0, uhts_pkg::ST_OK);
            conclude(uhts_pkg::ST_NORESP);
          end else begin
            case (phase)
              XF_SETUP: issue_next();
              XF_DATA_IN: begin
                push(uhts_pkg::ACT_UNLOAD, it.rx_count, uhts_pkg::ST_OK);
                push(uhts_pkg::ACT_CLEAR, '0, uhts_pkg::ST_OK);
                // Saturate on an oversized count; a short packet ends the data stage
                remaining = (it.rx_count >= remaining) ? '0 : remaining - it.rx_count;
                if (it.rx_count < pkt_len())
                  remaining = '0;
                issue_next();
              end
              XF_DATA_OUT: begin
                remaining = remaining - chunk();
                issue_next();
              end
              XF_STATUS_OUT: conclude(uhts_pkg::ST_OK);
              default: begin
                push(uhts_pkg::ACT_CLEAR, '0, uhts_pkg::ST_OK);
                conclude(uhts_pkg::ST_OK);
              end
            endcase
          end
        end
      end
      uhts_pkg::REQ_TICK: begin
        if (phase == XF_IDLE) begin
          taken = 1'b0;
        end else begin
          ticks = ticks + 16'd1;
          if (ticks == '0 || ticks >= tlim)
            conclude(uhts_pkg::ST_NORESP);
        end
      end
      default: taken = 1'b0;
    endcase
    foreach (burst[i]) begin
      c = burst[i];
      c.last = (i == burst.size() - 1);
      pending_cmds.push_back(c);
    end
    return taken;
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Check one accepted result transaction against the oldest queued command
  function void check_result(uhts_pkg::res_item_t got, logic got_last);
    cmd_t want;
    if (pending_cmds.size() == 0) begin
      $error("action: expected none, got %0d", got.action);
      mismatches++;
      return;
    end
    want = pending_cmds.pop_front();
    compare_field("action", 16'(want.body.action), 16'(got.action));
    compare_field("byte_count", 16'(want.body.byte_count), 16'(got.byte_count));
    compare_field("done_status", 16'(want.body.done_status), 16'(got.done_status));
    compare_field("last", 16'(want.last), 16'(got_last));
  endfunction
endclass

module usb_host_transfer_sequencer_tb;
  localparam logic [uhts_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CFG_SETTLE = 6;
  localparam int END_SETTLE = 16;
  localparam int XFER_CAP = 40;

  logic clk;
  logic rst;
  bit   calm;
  int   send_smooth;
  transfer_shadow shadow;

  uhts_req_if req_bus ();
  uhts_res_if res_bus ();
  uhts_cfg_if cfg_bus ();

  usb_host_transfer_sequencer u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus.sink),
    .res (res_bus.source),
    .cfg (cfg_bus.sink)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Fill every field with noise; builders then set the fields that matter
  function automatic uhts_pkg::req_item_t scrambled();
    uhts_pkg::req_item_t it;
    it.req_type = uhts_pkg::REQ_W'($urandom_range(0, 3));
    it.is_control = 1'($urandom_range(0, 1));
    it.dir_in = 1'($urandom_range(0, 1));
    it.total_length = uhts_pkg::LEN_W'($urandom_range(0, 65535));
    it.tx_pending = 1'($urandom_range(0, 1));
    it.rx_ready = 1'($urandom_range(0, 1));
    it.got_stall = 1'($urandom_range(0, 1));
    it.got_error = 1'($urandom_range(0, 1));
    it.got_nak_timeout = 1'($urandom_range(0, 1));
    it.rx_count = uhts_pkg::CNT_W'($urandom_range(0, 512));
    return it;
  endfunction

  function automatic uhts_pkg::req_item_t start_req(bit ctl, bit din,
                                                    logic [uhts_pkg::LEN_W-1:0] len);
    uhts_pkg::req_item_t it;
    it = scrambled();
    it.req_type = uhts_pkg::REQ_START;
    it.is_control = ctl;
    it.dir_in = din;
    it.total_length = len;
    return it;
  endfunction

  function automatic uhts_pkg::req_item_t event_req(bit txp, bit rxr, bit stall, bit err,
                                                    bit nak,
                                                    logic [uhts_pkg::CNT_W-1:0] rxc);
    uhts_pkg::req_item_t it;
    it = scrambled();
    it.req_type = uhts_pkg::REQ_EVENT;
    it.tx_pending = txp;
    it.rx_ready = rxr;
    it.got_stall = stall;
    it.got_error = err;
    it.got_nak_timeout = nak;
    it.rx_count = rxc;
    return it;
  endfunction

  function automatic uhts_pkg::req_item_t tick_req();
    uhts_pkg::req_item_t it;
    it = scrambled();
    it.req_type = uhts_pkg::REQ_TICK;
    return it;
  endfunction

  // Build an event that completes the current wait
  function automatic uhts_pkg::req_item_t completing(bit stall, bit err, bit nak,
                                                     logic [uhts_pkg::CNT_W-1:0] rxc);
    if (shadow.await_rx)
      return event_req(1'($urandom_range(0, 1)), 1'b1, stall, err, nak, rxc);
    return event_req(1'b0, 1'($urandom_range(0, 1)), stall, err, nak, rxc);
  endfunction

  // Drive one request transaction, hold it until accepted, then update the shadow
  task automatic send(input uhts_pkg::req_item_t it, output bit taken);
    int unsigned r;
    if (!calm) begin
      if (send_smooth > 0) begin
        send_smooth--;
      end else begin
        r = $urandom_range(0, 31);
        if (r < 5) begin
          req_bus.valid <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end else if (r == 5) begin
          send_smooth = $urandom_range(10, 40);
        end
      end
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= it.req_type;
    req_bus.is_control <= it.is_control;
    req_bus.dir_in <= it.dir_in;
    req_bus.total_length <= it.total_length;
    req_bus.tx_pending <= it.tx_pending;
    req_bus.rx_ready <= it.rx_ready;
    req_bus.got_stall <= it.got_stall;
    req_bus.got_error <= it.got_error;
    req_bus.got_nak_timeout <= it.got_nak_timeout;
    req_bus.rx_count <= it.rx_count;
    do @(posedge clk); while (!req_bus.ready);
    taken = shadow.note_request(it);
  endtask

  task automatic push_req(input uhts_pkg::req_item_t it);
    bit taken;
    send(it, taken);
  endtask

  // Drop valid and hold until every queued command has come out
  task automatic settle(input int extra);
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (shadow.pending_cmds.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_config(input logic [uhts_pkg::CFG_DAT_W-1:0] mps,
                            input logic [uhts_pkg::CFG_DAT_W-1:0] tlim);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= uhts_pkg::REG_MAX_PACKET;
    cfg_bus.data <= mps;
    do @(posedge clk); while (!cfg_bus.ready);
    shadow.set_reg(uhts_pkg::REG_MAX_PACKET, mps);
    cfg_bus.index <= uhts_pkg::REG_TIMEOUT;
    cfg_bus.data <= tlim;
    do @(posedge clk); while (!cfg_bus.ready);
    shadow.set_reg(uhts_pkg::REG_TIMEOUT, tlim);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random transfers, mostly well-formed, until the count is met and the block is idle
  task automatic run_phase(input int quota);
    uhts_pkg::req_item_t        it;
    bit                         taken;
    bit                         paused;
    int                         done_here;
    int                         span;
    int unsigned                ps;
    int unsigned                r;
    logic [2:0]                 fl;
    logic [uhts_pkg::CNT_W-1:0] rxc;
    done_here = 0;
    span = 0;
    paused = 1'b0;
    while (done_here < quota || shadow.phase != XF_IDLE) begin
      ps = shadow.pkt_len();
      fl = ($urandom_range(0, 9) < 8) ? 3'b000 : 3'($urandom_range(0, 7));
      if (shadow.phase == XF_DATA_IN) begin
        case ($urandom_range(0, 4))
          0, 1, 2: rxc = uhts_pkg::CNT_W'(ps);
          3:       rxc = uhts_pkg::CNT_W'($urandom_range(0, ps - 1));
          default: rxc = uhts_pkg::CNT_W'($urandom_range(0, 512));
        endcase
      end else begin
        rxc = uhts_pkg::CNT_W'($urandom_range(0, 512));
      end
      if (shadow.phase == XF_IDLE) begin
        span = 0;
        case ($urandom_range(0, 11))
          0: it = event_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), fl[2], fl[1],
                            fl[0], rxc);
          1: it = tick_req();
          2: begin
            it = scrambled();
            it.req_type = REQ_UNUSED;
          end
          default: begin
            case ($urandom_range(0, 9))
              0:       it = start_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      uhts_pkg::LEN_W'($urandom_range(0, 65535)));
              1:       it = start_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), '0);
              default: it = start_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      uhts_pkg::LEN_W'($urandom_range(1, 3 * ps + 2)));
            endcase
          end
        endcase
      end else if (span > XFER_CAP) begin
        // Cut off a long transfer with a stall
        it = completing(1'b1, 1'b0, 1'b0, rxc);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 68)
          it = completing(fl[2], fl[1], fl[0], rxc);
        else if (r < 80)
          it = shadow.await_rx ? event_req(1'($urandom_range(0, 1)), 1'b0, fl[2], fl[1], fl[0], rxc)
                               : event_req(1'b1, 1'($urandom_range(0, 1)), fl[2], fl[1], fl[0], rxc);
        else if (r < 93)
          it = tick_req();
        else if (r < 97)
          it = start_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         uhts_pkg::LEN_W'($urandom_range(0, 65535)));
        else begin
          it = scrambled();
          it.req_type = REQ_UNUSED;
        end
      end
      send(it, taken);
      if (taken) begin
        done_here++;
        span++;
      end
      // Hold the sender once per phase until all commands have drained
      if (!paused && done_here >= quota / 2) begin
        paused = 1'b1;
        settle(0);
      end
    end
  endtask

  // Accept result transactions with random stall bursts and check each one
  initial begin : result_sink
    uhts_pkg::res_item_t got;
    int                  hold;
    int                  smooth;
    int unsigned         r;
    hold = 0;
    smooth = 0;
    res_bus.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (res_bus.valid && res_bus.ready) begin
        got.action = res_bus.action;
        got.byte_count = res_bus.byte_count;
        got.done_status = res_bus.done_status;
        shadow.check_result(got, res_bus.last);
      end
      if (hold > 0) begin
        hold--;
        res_bus.ready <= 1'b0;
      end else if (calm || smooth > 0) begin
        if (smooth > 0)
          smooth--;
        res_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 31);
        if (r < 4) begin
          hold = $urandom_range(1, 14) - 1;
          res_bus.ready <= 1'b0;
        end else begin
          if (r == 4)
            smooth = $urandom_range(20, 80);
          res_bus.ready <= 1'b1;
        end
      end
    end
  end

  // End the run if no transaction moves on any channel for too long
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("usb_host_transfer_sequencer_tb: errors");
    $finish;
  end

  initial begin
    shadow = new();
    calm = 1'b0;
    send_smooth = 0;
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= uhts_pkg::REQ_START;
    req_bus.is_control <= 1'b0;
    req_bus.dir_in <= 1'b0;
    req_bus.total_length <= '0;
    req_bus.tx_pending <= 1'b0;
    req_bus.rx_ready <= 1'b0;
    req_bus.got_stall <= 1'b0;
    req_bus.got_error <= 1'b0;
    req_bus.got_nak_timeout <= 1'b0;
    req_bus.rx_count <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= uhts_pkg::REG_MAX_PACKET;
    cfg_bus.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: ignored requests first
    push_req(event_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0));
    push_req(tick_req());
    push_req('{req_type: REQ_UNUSED, default: '0});
    // Empty bulk transfers finish at once
    push_req(start_req(1'b0, 1'b0, 16'd0));
    push_req(start_req(1'b0, 1'b1, 16'd0));
    // Control OUT in two packets, with a start while busy and non-completing events
    push_req(start_req(1'b1, 1'b0, 16'd100));
    push_req(event_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0));
    push_req(start_req(1'b1, 1'b1, 16'd5));
    push_req(event_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0));
    push_req(tick_req());
    push_req(event_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0));
    push_req(event_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0));
    push_req(event_req(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0));
    push_req(event_req(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0));
    // Control IN of maximum length, ended by a short packet
    push_req(start_req(1'b1, 1'b1, 16'hFFFF));
    push_req(event_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0));
    push_req(event_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 10'd64));
    push_req(event_req(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 10'd5));
    push_req(event_req(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0));
    // Bulk IN with an oversized count
    push_req(start_req(1'b0, 1'b1, 16'd70));
    push_req(event_req(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 10'd512));
    // Stall, bus error and NAK timeout endings
    push_req(start_req(1'b0, 1'b0, 16'd10));
    push_req(event_req(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 10'd0));
    push_req(start_req(1'b1, 1'b1, 16'd8));
    push_req(event_req(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0));
    push_req(start_req(1'b0, 1'b1, 16'd30));
    push_req(event_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 10'd30));
    run_phase(40);

    // Small packets, short timeout: run a transfer into the timeout
    settle(CFG_SETTLE);
    set_config(16'd8, 16'd3);
    push_req(start_req(1'b0, 1'b0, 16'd20));
    push_req(tick_req());
    push_req(tick_req());
    push_req(tick_req());
    run_phase(40);

    settle(CFG_SETTLE);
    set_config(16'd512, 16'hFFFF);
    run_phase(40);

    // Packet size zero counts as one byte; timeout limit zero ends on the first tick
    settle(CFG_SETTLE);
    set_config(16'd0, 16'd0);
    push_req(start_req(1'b0, 1'b1, 16'd2));
    push_req(event_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 10'd1));
    push_req(tick_req());
    push_req(start_req(1'b1, 1'b0, 16'd1));
    push_req(tick_req());
    run_phase(35);

    settle(CFG_SETTLE);
    set_config(16'd1, 16'd1);
    run_phase(35);

    // Last stretch with no idling on either side
    settle(CFG_SETTLE);
    calm = 1'b1;
    set_config(16'd37, 16'd12);
    run_phase(35);

    settle(END_SETTLE);
    if (shadow.pending_cmds.size() != 0) begin
      $error("action: %0d commands never arrived", shadow.pending_cmds.size());
      shadow.mismatches++;
    end
    if (shadow.mismatches == 0)
      $display("usb_host_transfer_sequencer_tb: clean");
    else
      $display("usb_host_transfer_sequencer_tb: errors");
    $finish;
  end
endmodule

>>> filelist.f
design/uhts_pkg.sv
design/uhts_req_if.sv
design/uhts_res_if.sv
design/uhts_cfg_if.sv
design/usb_host_transfer_sequencer.sv
dv/usb_host_transfer_sequencer_tb.sv
